// ===== hw/rtl/fbpa_pkg.sv =====
`default_nettype none
package fbpa_pkg;

  // Pool geometry limits
  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);

  // Fixed field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned BytesW = 16;
  localparam int unsigned CountW = 9;
  localparam int unsigned SpanW  = BytesW + CountW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] MaxBlocksCnt = CountW'(MaxBlocks);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPoolBase   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBytes = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlockTotal = 2'd2;

  typedef enum logic [1:0] {
    OpInit  = 2'd0,
    OpAlloc = 2'd1,
    OpFree  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StatOk      = 3'd0,
    StatInvalid = 3'd1,
    StatEmpty   = 3'd2,
    StatFull    = 3'd3,
    StatNotInit = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StExec = 2'd1,
    StPop  = 2'd2
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
  } fbpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_pending;
  } fbpa_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fbpa_ram.sv =====
`default_nettype none
module fbpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fbpa_ctrl.sv =====
`default_nettype none
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire fbpa_stat_t stat_i,
  output fbpa_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StExec;
      end
      StExec: begin
        state_d = stat_i.pop_pending ? StPop : StIdle;
      end
      StPop: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
      end
      StPop: begin
        cmd_o.pop = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // a stack pop passes through StPop for the registered read, then returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPop) |=> (state_q == StIdle))
    else $error("pop state held longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPop) |-> ($past(state_q) == StExec))
    else $error("pop state entered without an execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StExec))
    else $error("accepted item not executed in the next cycle");

endmodule
`default_nettype wire

// ===== hw/rtl/fbpa_dp.sv =====
`default_nettype none
module fbpa_dp
  import fbpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [AddrW-1:0]   block_address_i,
  input  wire fbpa_cmd_t          cmd_i,
  output fbpa_stat_t              stat_o,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [AddrW-1:0]        granted_address_o,
  output logic [CountW-1:0]       free_blocks_o
);

  function automatic logic [CountW-1:0] calc_free(
    input logic              ready,
    input logic [CountW-1:0] cnt,
    input logic [CountW-1:0] total,
    input logic [CountW-1:0] unt
  );
    return ready ? (cnt + (total - unt)) : '0;
  endfunction

  // configuration registers
  logic [AddrW-1:0]  cfg_base_q;
  logic [BytesW-1:0] cfg_bytes_q;
  logic [CountW-1:0] cfg_total_q;

  // pool state
  logic [AddrW-1:0]  lat_base_q, lat_base_d;
  logic [BytesW-1:0] lat_bytes_q, lat_bytes_d;
  logic [CountW-1:0] lat_total_q, lat_total_d;
  logic [SpanW-1:0]  span_q, span_d;
  logic [CountW-1:0] ret_cnt_q, ret_cnt_d;
  logic [CountW-1:0] unt_q, unt_d;
  logic [AddrW-1:0]  fresh_q, fresh_d;
  logic              ready_q, ready_d;

  // request and result
  logic [1:0]        op_q;
  logic [AddrW-1:0]  addr_q;
  logic              done_q, done_d;
  logic [2:0]        status_q, status_d;
  logic [AddrW-1:0]  granted_q, granted_d;
  logic [CountW-1:0] free_q, free_d;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_rdata;
  logic [AddrW:0]    limit;
  logic              cur_pop;

  assign limit   = {1'b0, lat_base_q} + (AddrW+1)'(span_q);
  assign cur_pop = (op_q == OpAlloc) && ready_q && (ret_cnt_q != '0);
  assign stat_o.pop_pending = cur_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_bytes_q <= BytesW'(4);
      cfg_total_q <= CountW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPoolBase:   cfg_base_q  <= cfg_data_i;
        CfgBlockBytes: cfg_bytes_q <= cfg_data_i[BytesW-1:0];
        CfgBlockTotal: cfg_total_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lat_base_d  = lat_base_q;
    lat_bytes_d = lat_bytes_q;
    lat_total_d = lat_total_q;
    span_d      = span_q;
    ret_cnt_d   = ret_cnt_q;
    unt_d       = unt_q;
    fresh_d     = fresh_q;
    ready_d     = ready_q;
    status_d    = StatOk;
    granted_d   = '0;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (cmd_i.exec) begin
      done_d = !cur_pop;
      case (op_q)
        OpInit: begin
          if (cfg_bytes_q < BytesW'(4) || cfg_total_q == '0 || cfg_total_q > MaxBlocksCnt) begin
            status_d = StatInvalid;
          end else begin
            lat_base_d  = cfg_base_q;
            lat_bytes_d = cfg_bytes_q;
            lat_total_d = cfg_total_q;
            span_d      = SpanW'(cfg_bytes_q) * SpanW'(cfg_total_q);
            ret_cnt_d   = '0;
            unt_d       = '0;
            fresh_d     = cfg_base_q;
            ready_d     = 1'b1;
          end
        end
        OpAlloc: begin
          if (!ready_q) begin
            status_d = StatNotInit;
          end else if (cur_pop) begin
            ret_cnt_d = ret_cnt_q - CountW'(1);
            ram_re    = 1'b1;
          end else if (unt_q < lat_total_q) begin
            granted_d = fresh_q;
            unt_d     = unt_q + CountW'(1);
            fresh_d   = fresh_q + AddrW'(lat_bytes_q);
          end else begin
            status_d = StatEmpty;
          end
        end
        OpFree: begin
          if (!ready_q) begin
            status_d = StatNotInit;
          end else if (addr_q < lat_base_q || {1'b0, addr_q} >= limit) begin
            status_d = StatInvalid;
          end else if (calc_free(ready_q, ret_cnt_q, lat_total_q, unt_q) >= lat_total_q
                       || ret_cnt_q >= MaxBlocksCnt) begin
            status_d = StatFull;
          end else begin
            ram_we    = 1'b1;
            ret_cnt_d = ret_cnt_q + CountW'(1);
          end
        end
        default: status_d = StatInvalid;
      endcase
    end else if (cmd_i.pop) begin
      done_d    = 1'b1;
      granted_d = ram_rdata;
    end
    free_d = calc_free(ready_d, ret_cnt_d, lat_total_d, unt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_base_q  <= '0;
      lat_bytes_q <= '0;
      lat_total_q <= '0;
      span_q      <= '0;
      ret_cnt_q   <= '0;
      unt_q       <= '0;
      fresh_q     <= '0;
      ready_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      lat_base_q  <= lat_base_d;
      lat_bytes_q <= lat_bytes_d;
      lat_total_q <= lat_total_d;
      span_q      <= span_d;
      ret_cnt_q   <= ret_cnt_d;
      unt_q       <= unt_d;
      fresh_q     <= fresh_d;
      ready_q     <= ready_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      addr_q <= block_address_i;
    end
    if (done_d) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      free_q    <= free_d;
    end
  end

  // stack of returned blocks; top entry is ret_cnt_q - 1
  fbpa_ram #(
    .Width(AddrW),
    .Depth(MaxBlocks)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ret_cnt_q[IdxW-1:0]),
    .wdata_i(addr_q),
    .re_i   (ram_re),
    .raddr_i(ret_cnt_d[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign free_blocks_o     = free_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_cnt_q <= MaxBlocksCnt)
    else $error("returned stack overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (unt_q <= lat_total_q))
    else $error("untouched index past pool end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe on two consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> ($past(ret_cnt_q) == ret_cnt_q + CountW'(1)))
    else $error("pop finished without a stack decrement");

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
`default_nettype none
// Channel   Signals                                       Handshake
// config    cfg_we_i, cfg_idx_i, cfg_data_i               write at clk when cfg_we_i
// request   opcode_i, block_address_i                     taken when start && !busy
// result    status_o, granted_address_o, free_blocks_o    valid one cycle with done_o
//
// A taken request is latched, executed in StExec, and done_o is registered from that; an alloc
// served from the stack of returned blocks also passes through StPop, the extra state being the
// registered read of the stack RAM. busy falls as done_o rises, so no new request is taken before
// the last one is done. Reset clears all pool state; the stack RAM is not cleared, since entries
// are read only after being written. Results cannot be stalled.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [AddrW-1:0]   block_address_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [AddrW-1:0]        granted_address_o,
  output logic [CountW-1:0]       free_blocks_o
);

  fbpa_cmd_t  cmd;
  fbpa_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  fbpa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .block_address_i  (block_address_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_address_o(granted_address_o),
    .free_blocks_o    (free_blocks_o)
  );

endmodule
`default_nettype wire

// ===== sim/fixed_block_pool_allocator_tb.sv =====
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam logic [1:0]         OpUndef    = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare   = 2'd3;
  localparam int unsigned        CycleLimit = 200000;
  localparam int unsigned        ShownMax   = 10;

  typedef struct {
    status_e           status;
    logic [AddrW-1:0]  granted;
    logic [CountW-1:0] free_cnt;
  } pool_reply_t;

  // Shadow of the pool: registers, latched geometry, returned-block stack
  class pool_tracker;
    logic [AddrW-1:0]  reg_base;
    logic [BytesW-1:0] reg_bytes;
    logic [CountW-1:0] reg_total;
    logic [AddrW-1:0]  lat_base;
    logic [BytesW-1:0] lat_bytes;
    logic [CountW-1:0] lat_total;
    logic [AddrW-1:0]  freed_stack [MaxBlocks];
    int unsigned       freed_count;
    int unsigned       fresh_index;
    logic [AddrW-1:0]  fresh_addr;
    bit                ready;
    pool_reply_t       pending_replies [$];
    int unsigned       mismatches;

    function new();
      reg_base    = '0;
      reg_bytes   = 16'd4;
      reg_total   = 9'd1;
      lat_base    = '0;
      lat_bytes   = '0;
      lat_total   = '0;
      freed_count = 0;
      fresh_index = 0;
      fresh_addr  = '0;
      ready       = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] val);
      case (idx)
        CfgPoolBase:   reg_base  = val;
        CfgBlockBytes: reg_bytes = val[BytesW-1:0];
        CfgBlockTotal: reg_total = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned free_now();
      int unsigned untouched;
      if (!ready) return 0;
      untouched = (lat_total > fresh_index) ? lat_total - fresh_index : 0;
      return (freed_count + untouched) & 32'h1FF;
    endfunction

    function void take_request(logic [1:0] op, logic [AddrW-1:0] addr);
      pool_reply_t     r;
      longint unsigned limit;
      r.status  = StatOk;
      r.granted = '0;
      if (op == OpInit) begin
        if (reg_bytes < 4 || reg_total == 0 || reg_total > MaxBlocks) begin
          r.status = StatInvalid;
        end else begin
          lat_base    = reg_base;
          lat_bytes   = reg_bytes;
          lat_total   = reg_total;
          freed_count = 0;
          fresh_index = 0;
          fresh_addr  = reg_base;
          ready       = 1'b1;
        end
      end else if (op == OpUndef) begin
        r.status = StatInvalid;
      end else if (!ready) begin
        r.status = StatNotInit;
      end else if (op == OpAlloc) begin
        if (freed_count > 0 && freed_count <= MaxBlocks) begin
          freed_count--;
          r.granted = freed_stack[freed_count];
        end else if (fresh_index < lat_total) begin
          r.granted = fresh_addr;
          fresh_index++;
          fresh_addr = fresh_addr + AddrW'(lat_bytes);
        end else begin
          r.status = StatEmpty;
        end
      end else begin
        // range check is done without wrap
        limit = 64'(lat_base) + 64'(lat_bytes) * 64'(lat_total);
        if (64'(addr) < 64'(lat_base) || 64'(addr) >= limit) begin
          r.status = StatInvalid;
        end else if (free_now() >= lat_total || freed_count >= MaxBlocks) begin
          r.status = StatFull;
        end else begin
          freed_stack[freed_count] = addr;
          freed_count++;
        end
      end
      r.free_cnt = CountW'(free_now());
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [2:0] st, logic [AddrW-1:0] ga, logic [CountW-1:0] fb);
      pool_reply_t e;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMax)
          $display("%0t: unexpected result: status %0d addr %h free %0d", $time, st, ga, fb);
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status || ga !== e.granted || fb !== e.free_cnt) begin
        mismatches++;
        if (mismatches <= ShownMax)
          $display("%0t: mismatch: exp status %0d addr %h free %0d, got status %0d addr %h free %0d",
                   $time, e.status, e.granted, e.free_cnt, st, ga, fb);
      end
    endfunction
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i       = '0;
  logic [AddrW-1:0]   cfg_data_i      = '0;
  logic               start           = 1'b0;
  logic [1:0]         opcode_i        = '0;
  logic [AddrW-1:0]   block_address_i = '0;
  logic               busy;
  logic               done_o;
  logic [2:0]         status_o;
  logic [AddrW-1:0]   granted_address_o;
  logic [CountW-1:0]  free_blocks_o;

  pool_tracker tracker = new();
  int unsigned idle_pct = 24;
  int unsigned cycle_count = 0;

  fixed_block_pool_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .block_address_i   (block_address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_blocks_o     (free_blocks_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.write_reg(cfg_idx_i, cfg_data_i);
      if (start && !busy) tracker.take_request(opcode_i, block_address_i);
      if (done_o) tracker.check_reply(status_o, granted_address_o, free_blocks_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [AddrW-1:0] addr);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start           <= 1'b1;
    opcode_i        <= op;
    block_address_i <= addr;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [AddrW-1:0] base, input logic [BytesW-1:0] bytes,
                             input logic [CountW-1:0] total, input bit poke_spare);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgPoolBase;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx_i  <= CfgBlockBytes;
    cfg_data_i <= AddrW'(bytes);
    @(posedge clk_i);
    cfg_idx_i  <= CfgBlockTotal;
    cfg_data_i <= AddrW'(total);
    @(posedge clk_i);
    if (poke_spare) begin
      cfg_idx_i  <= CfgSpare;
      cfg_data_i <= $urandom();
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly addresses inside the pool, some at its edges, some anywhere
  function automatic logic [AddrW-1:0] pick_free_addr();
    longint unsigned span;
    span = 64'(tracker.lat_bytes) * 64'(tracker.lat_total);
    if (span == 0) return $urandom();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return tracker.lat_base - 1;
      3:       return AddrW'(64'(tracker.lat_base) + span);
      4:       return AddrW'(64'(tracker.lat_base) + span - 1);
      5:       return tracker.lat_base + AddrW'($urandom_range(0, 32'(span) - 1));
      default: return tracker.lat_base
                      + AddrW'(tracker.lat_bytes) * $urandom_range(0, tracker.lat_total - 1);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before any init
    issue(OpAlloc, '0);
    issue(OpFree, '0);
    issue(OpUndef, $urandom());
    // rejected geometries
    reconfigure('0, 16'd3, 9'd1, 1'b0);
    issue(OpInit, '0);
    reconfigure('0, 16'd4, 9'd0, 1'b0);
    issue(OpInit, '0);
    reconfigure('0, 16'd4, 9'd511, 1'b1);
    issue(OpInit, '0);
    issue(OpAlloc, '0);
    // two-block pool at address zero: drain, refill, LIFO order, rebuild
    reconfigure('0, 16'd4, 9'd2, 1'b0);
    issue(OpInit, '0);
    issue(OpAlloc, '0);
    issue(OpAlloc, '0);
    issue(OpAlloc, '0);
    issue(OpFree, 32'd8);
    issue(OpFree, 32'd3);
    issue(OpFree, 32'd0);
    issue(OpFree, 32'd4);
    issue(OpAlloc, '0);
    wait_drained();
    issue(OpInit, '0);
    // pool running off the top of the address space
    reconfigure(32'hFFFF_FFF8, 16'hFFFF, 9'd256, 1'b0);
    issue(OpInit, '1);
    issue(OpAlloc, '0);
    issue(OpAlloc, '0);
    issue(OpFree, 32'hFFFF_FFF8);
    issue(OpFree, 32'hFFFF_FFFF);
    issue(OpFree, 32'h0000_0000);
    // failed init keeps the live pool
    reconfigure(32'hFFFF_FFF8, 16'd0, 9'd256, 1'b0);
    issue(OpInit, '0);
    issue(OpAlloc, '0);

    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 24 : (ph < 6) ? 49 : 0;
      case (ph)
        0: reconfigure('0, 16'd4, 9'd1, 1'b0);
        1: reconfigure(32'hFFFF_0000, 16'hFFFF, 9'd256, 1'b0);
        2: reconfigure($urandom(), BytesW'($urandom_range(4, 64)),
                       CountW'($urandom_range(1, 8)), 1'b0);
        3: reconfigure($urandom(), 16'd4, 9'd256, 1'b1);
        4: reconfigure($urandom(), BytesW'($urandom_range(4, 65535)),
                       CountW'($urandom_range(1, 16)), 1'b0);
        // invalid size: the pool from the previous setting stays live
        5: reconfigure($urandom(), BytesW'($urandom_range(0, 3)),
                       CountW'($urandom_range(1, 256)), 1'b0);
        6: reconfigure($urandom(), BytesW'($urandom_range(4, 300)),
                       CountW'($urandom_range(1, 32)), 1'b0);
        7: reconfigure('0, 16'hFFFF, CountW'($urandom_range(1, 4)), 1'b0);
        default: reconfigure($urandom(), BytesW'($urandom_range(4, 16)),
                             CountW'($urandom_range(2, 12)), 1'b0);
      endcase
      issue(OpInit, $urandom());
      for (int n = 0; n < 200; n++) begin
        int unsigned roll;
        int unsigned alloc_pct;
        roll = $urandom_range(0, 99);
        // swing between filling and emptying the pool
        alloc_pct = ((n / 40) % 2) ? 70 : 35;
        if ($urandom_range(0, 199) == 0) wait_drained();
        if (roll < 2)
          issue(OpInit, $urandom());
        else if (roll < 5)
          issue(OpUndef, $urandom());
        else if (roll < 5 + alloc_pct)
          issue(OpAlloc, $urandom());
        else
          issue(OpFree, pick_free_addr());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.pending_replies.size() != 0) tracker.mismatches++;
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
